### sv/fde_pkg.sv
// shared types and constants of the framebuffer draw engine
// request and response payloads, opcodes, register indexes, control/status bundles
// no dependencies
package fde_pkg;

  localparam int IN_W      = 12;   // width of the signed coordinate fields
  localparam int CW        = 14;   // internal coordinate width, holds every sum
  localparam int COLOR_W   = 32;
  localparam int CNT_W     = 17;
  localparam int AREA_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 32;
  localparam int SQ_IN_W   = 24;   // radicand width for the circle spans
  localparam int SQ_ROOT_W = 12;

  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_RECT   = 3'd2;
  localparam logic [2:0] OP_CIRCLE = 3'd3;
  localparam logic [2:0] OP_LINE   = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_ENABLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR  = 2'd3;

  localparam logic [AREA_W-1:0] AREA_RESET = 9'd256;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic [2:0]              req_type;
    logic signed [IN_W-1:0]  x_a;
    logic signed [IN_W-1:0]  y_a;
    logic signed [IN_W-1:0]  x_b;
    logic signed [IN_W-1:0]  y_b;
    logic [COLOR_W-1:0]      draw_color;
  } req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] read_color;
    logic [CNT_W-1:0]   pixels_written;
    logic               range_error;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd_issue;
    logic rd_take;
    logic put;
    logic rect_init;
    logic rect_next;
    logic circ_init;
    logic circ_sq;
    logic sqrt_start;
    logic circ_span;
    logic col_next;
    logic row_next;
    logic line_init;
    logic div_start_x;
    logic div_start_y;
    logic take_x;
    logic take_y;
    logic line_pos;
    logic clr_step;
    logic clr_zero;
    logic rsp_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pix_in;
    logic rect_empty;
    logic rect_last;
    logic circ_none;
    logic span_empty;
    logic col_last;
    logic row_last;
    logic sqrt_done;
    logic line_zero;
    logic div_done;
    logic line_last;
    logic clr_last;
  } sts_t;

endpackage

### sv/fde_sqrt.sv
// iterative integer square root, two radicand bits per cycle
// uses fde_pkg widths
module fde_sqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [fde_pkg::SQ_IN_W-1:0]     radicand,
  output logic [fde_pkg::SQ_ROOT_W-1:0]   root,
  output logic                            done
);
  import fde_pkg::*;

  localparam int RW = SQ_ROOT_W + 2;

  logic [SQ_IN_W-1:0]   v;
  logic [SQ_ROOT_W-1:0] q;
  logic [RW-1:0]        rem;
  logic [3:0]           cnt;
  logic                 busy;
  logic [RW-1:0]        rem2;
  logic [RW-1:0]        trial;
  logic                 ge;

  assign rem2  = {rem[RW-3:0], v[SQ_IN_W-1 -: 2]};
  assign trial = {q, 2'b01};
  assign ge    = rem2 >= trial;
  assign root  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v    <= radicand;
        q    <= '0;
        rem  <= '0;
        cnt  <= 4'(SQ_ROOT_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? rem2 - trial : rem2;
        q   <= {q[SQ_ROOT_W-2:0], ge};
        v   <= {v[SQ_IN_W-3:0], 2'b00};
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 4'd1;
        end
      end
    end
  end

endmodule

### sv/fde_div.sv
// restoring unsigned divider, one quotient bit per cycle
// no package dependency
module fde_div #(
  parameter int NW = 28,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quotient,
  output logic          done
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   nq;
  logic [DW:0]     rem;
  logic [DW-1:0]   dsr;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [DW:0]     r2;
  logic            ge;

  assign r2       = {rem[DW-1:0], nq[NW-1]};
  assign ge       = r2 >= {1'b0, dsr};
  assign quotient = nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        nq   <= dividend;
        rem  <= '0;
        dsr  <= divisor;
        cnt  <= CNTW'(NW - 1);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? r2 - {1'b0, dsr} : r2;
        nq  <= {nq[NW-2:0], ge};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNTW'(1);
        end
      end
    end
  end

endmodule

### sv/fde_dp.sv
// datapath: pixel store, configuration registers, coordinate walkers, result register
// uses fde_pkg, fde_sqrt and fde_div
module fde_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fde_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fde_pkg::CFG_DW-1:0]        cfg_data,
  input  fde_pkg::req_t                     req,
  input  fde_pkg::cmd_t                     cmd,
  output fde_pkg::sts_t                     sts,
  output fde_pkg::rsp_t                     rsp
);
  import fde_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = IN_W + 1 + FRAC_BITS;
  localparam int NW    = IN_W + FRAC_BITS;

  // configuration
  logic [AREA_W-1:0]  area_width;
  logic [AREA_W-1:0]  area_height;
  logic               clip_enable;
  logic [COLOR_W-1:0] clear_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_width  <= AREA_RESET;
      area_height <= AREA_RESET;
      clip_enable <= 1'b1;
      clear_color <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AREA_WIDTH:  area_width  <= cfg_data[AREA_W-1:0];
        REG_AREA_HEIGHT: area_height <= cfg_data[AREA_W-1:0];
        REG_CLIP_ENABLE: clip_enable <= cfg_data[0];
        REG_FILL_COLOR:  clear_color <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  coord_t aw, ah;
  assign aw = (CW'(area_width) > CW'(MAX_WIDTH)) ? coord_t'(CW'(MAX_WIDTH))
                                                 : coord_t'(CW'(area_width));
  assign ah = (CW'(area_height) > CW'(MAX_HEIGHT)) ? coord_t'(CW'(MAX_HEIGHT))
                                                   : coord_t'(CW'(area_height));

  // latched request
  req_t   r;
  coord_t xa, ya, xb, yb;
  always_ff @(posedge clk) begin
    if (cmd.load) r <= req;
  end
  assign xa = coord_t'(r.x_a);
  assign ya = coord_t'(r.y_a);
  assign xb = coord_t'(r.x_b);
  assign yb = coord_t'(r.y_b);

  // current pixel
  coord_t cur_x, cur_y;
  logic   pix_in;
  assign pix_in = (cur_x >= coord_t'(0)) && (cur_y >= coord_t'(0)) &&
                  (cur_x < aw) && (cur_y < ah);

  logic [AW+CW-1:0] addr_w;
  logic [AW-1:0]    pix_addr;
  assign addr_w   = (AW+CW)'(cur_y[CW-2:0]) * (AW+CW)'(MAX_WIDTH) +
                    (AW+CW)'(cur_x[CW-2:0]);
  assign pix_addr = addr_w[AW-1:0];

  // rectangle bounds
  coord_t x0c, y0c, x1s, y1s, x1c, y1c;
  coord_t rx0, rxl, ryl;
  logic   rect_empty;
  assign x0c = (xa < coord_t'(0)) ? coord_t'(0) : xa;
  assign y0c = (ya < coord_t'(0)) ? coord_t'(0) : ya;
  assign x1s = xa + xb;
  assign y1s = ya + yb;
  assign x1c = (x1s > aw) ? aw : x1s;
  assign y1c = (y1s > ah) ? ah : y1s;

  // circle rows
  logic signed [2*IN_W-1:0] rprod;
  logic [SQ_IN_W-1:0]       rr, dysq;
  coord_t                   cj, jl, cdy, cend;
  logic signed [2*CW-1:0]   dyp;
  logic                     span_empty;
  logic [SQ_ROOT_W-1:0]     root;
  logic                     sqrt_done;
  coord_t                   mc, rm1, mm, lo, hi, cl, ch;
  logic                     row_ok;

  assign rprod  = r.x_b * r.x_b;
  assign cdy    = cj - ya;
  assign dyp    = cdy * cdy;
  assign mc     = coord_t'({2'b00, root});
  assign rm1    = xb - coord_t'(1);
  assign mm     = (mc < rm1) ? mc : rm1;
  assign lo     = xa - mc;
  assign hi     = xa + mm;
  assign cl     = (lo < coord_t'(0)) ? coord_t'(0) : lo;
  assign ch     = (hi > aw - coord_t'(1)) ? aw - coord_t'(1) : hi;
  assign row_ok = (cj >= coord_t'(0)) && (cj < ah);

  fde_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (rr - dysq),
    .root     (root),
    .done     (sqrt_done)
  );

  // line walker
  coord_t                dxc, dyc, adx, ady;
  logic [IN_W-1:0]       ldx_abs, ldy_abs, len, li;
  logic                  ldx_neg, ldy_neg;
  logic signed [PW-1:0]  px, py, sx, sy, qs;
  logic [NW-1:0]         dq;
  logic                  div_done;
  logic [PW-1:0]         magx, magy, shx, shy;
  coord_t                tx, ty;

  assign dxc = xb - xa;
  assign dyc = yb - ya;
  assign adx = (dxc < coord_t'(0)) ? -dxc : dxc;
  assign ady = (dyc < coord_t'(0)) ? -dyc : dyc;

  fde_div #(.NW(NW), .DW(IN_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start_x | cmd.div_start_y),
    .dividend ({(cmd.div_start_y ? ldy_abs : ldx_abs), {FRAC_BITS{1'b0}}}),
    .divisor  (len),
    .quotient (dq),
    .done     (div_done)
  );

  assign qs = PW'(dq[FRAC_BITS:0]);

  // coordinate is the position truncated toward zero
  assign magx = px[PW-1] ? -px : px;
  assign magy = py[PW-1] ? -py : py;
  assign shx  = magx >> FRAC_BITS;
  assign shy  = magy >> FRAC_BITS;
  assign tx   = px[PW-1] ? -coord_t'(shx[CW-1:0]) : coord_t'(shx[CW-1:0]);
  assign ty   = py[PW-1] ? -coord_t'(shy[CW-1:0]) : coord_t'(shy[CW-1:0]);

  // walkers and circle/line registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x <= coord_t'(req.x_a);
      cur_y <= coord_t'(req.y_a);
    end else if (cmd.rect_init) begin
      cur_x <= x0c;
      cur_y <= y0c;
    end else if (cmd.rect_next) begin
      if (cur_x == rxl) begin
        cur_x <= rx0;
        cur_y <= cur_y + coord_t'(1);
      end else begin
        cur_x <= cur_x + coord_t'(1);
      end
    end else if (cmd.circ_span) begin
      cur_x <= cl;
      cur_y <= cj;
    end else if (cmd.col_next) begin
      cur_x <= cur_x + coord_t'(1);
    end else if (cmd.line_pos) begin
      cur_x <= tx;
      cur_y <= ty;
    end

    if (cmd.rect_init) begin
      rx0        <= x0c;
      rxl        <= x1c - coord_t'(1);
      ryl        <= y1c - coord_t'(1);
      rect_empty <= !((xb > coord_t'(0)) && (yb > coord_t'(0))) ||
                    (x0c >= x1c) || (y0c >= y1c);
    end

    if (cmd.circ_init) begin
      rr <= SQ_IN_W'(rprod);
      cj <= ya - xb;
      jl <= ya + xb - coord_t'(1);
    end else if (cmd.row_next) begin
      cj <= cj + coord_t'(1);
    end
    if (cmd.circ_sq) dysq <= dyp[SQ_IN_W-1:0];
    if (cmd.circ_span) begin
      cend       <= ch;
      span_empty <= !row_ok || (cl > ch);
    end

    if (cmd.line_init) begin
      ldx_abs <= adx[IN_W-1:0];
      ldy_abs <= ady[IN_W-1:0];
      ldx_neg <= dxc < coord_t'(0);
      ldy_neg <= dyc < coord_t'(0);
      len     <= (adx > ady) ? adx[IN_W-1:0] : ady[IN_W-1:0];
      px      <= PW'(xa) <<< FRAC_BITS;
      py      <= PW'(ya) <<< FRAC_BITS;
      li      <= '0;
    end else if (cmd.line_pos) begin
      px <= px + sx;
      py <= py + sy;
      li <= li + IN_W'(1);
    end
    if (cmd.take_x) sx <= ldx_neg ? -qs : qs;
    if (cmd.take_y) sy <= ldy_neg ? -qs : qs;
  end

  // pixel store with a sweep counter for clear and the post-reset clearing pass
  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rdq;
  logic [AW-1:0]      clr_addr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [COLOR_W-1:0] wdata;

  assign we    = (cmd.put && pix_in) || cmd.clr_step;
  assign waddr = cmd.clr_step ? clr_addr : pix_addr;
  assign wdata = cmd.clr_step ? (cmd.clr_zero ? '0 : clear_color) : r.draw_color;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd_issue) rdq <= mem[pix_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.load) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= (clr_addr == AW'(DEPTH - 1)) ? '0 : clr_addr + AW'(1);
    end
  end

  // result accumulation
  logic [COLOR_W-1:0] rd_col;
  logic [CNT_W-1:0]   cnt;
  logic               err;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_col <= '0;
      cnt    <= '0;
      err    <= 1'b0;
    end else begin
      if (cmd.rd_take) rd_col <= rdq;
      if (cmd.clr_step) cnt <= CNT_W'(DEPTH);
      else if (cmd.put && pix_in) cnt <= cnt + CNT_W'(1);
      if ((cmd.put && !pix_in && !clip_enable) || (cmd.rd_issue && !pix_in)) err <= 1'b1;
      if (cmd.circ_span && !clip_enable &&
          (!row_ok || (cl != lo) || (ch != hi) || (cl > ch))) err <= 1'b1;
    end
    if (cmd.rsp_load) begin
      rsp.read_color     <= rd_col;
      rsp.pixels_written <= cnt;
      rsp.range_error    <= err;
    end
  end

  always_comb begin
    sts.pix_in     = pix_in;
    sts.rect_empty = rect_empty;
    sts.rect_last  = (cur_x == rxl) && (cur_y == ryl);
    sts.circ_none  = xb <= coord_t'(0);
    sts.span_empty = span_empty;
    sts.col_last   = cur_x == cend;
    sts.row_last   = cj == jl;
    sts.sqrt_done  = sqrt_done;
    sts.line_zero  = len == '0;
    sts.div_done   = div_done;
    sts.line_last  = li == len;
    sts.clr_last   = clr_addr == AW'(DEPTH - 1);
  end

endmodule

### sv/fde_ctrl.sv
// controller: sequences each command over the datapath, owns the handshakes
// uses fde_pkg
module fde_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  logic [2:0]    req_type,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output fde_pkg::cmd_t cmd,
  input  fde_pkg::sts_t sts
);
  import fde_pkg::*;

  localparam logic [4:0] S_INIT   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_RD     = 5'd2;
  localparam logic [4:0] S_RD2    = 5'd3;
  localparam logic [4:0] S_WR     = 5'd4;
  localparam logic [4:0] S_RINIT  = 5'd5;
  localparam logic [4:0] S_RECT   = 5'd6;
  localparam logic [4:0] S_CINIT  = 5'd7;
  localparam logic [4:0] S_CSQ    = 5'd8;
  localparam logic [4:0] S_CSQRT0 = 5'd9;
  localparam logic [4:0] S_CSQRT  = 5'd10;
  localparam logic [4:0] S_CSPAN  = 5'd11;
  localparam logic [4:0] S_CPIX   = 5'd12;
  localparam logic [4:0] S_LINIT  = 5'd13;
  localparam logic [4:0] S_LCHK   = 5'd14;
  localparam logic [4:0] S_LDX    = 5'd15;
  localparam logic [4:0] S_LDY    = 5'd16;
  localparam logic [4:0] S_LPOS   = 5'd17;
  localparam logic [4:0] S_LPUT   = 5'd18;
  localparam logic [4:0] S_CLR    = 5'd19;
  localparam logic [4:0] S_DONE   = 5'd20;

  logic [4:0] state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = 1'b0;
    case (state)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        cmd.clr_zero = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load = 1'b1;
          case (req_type)
            OP_READ:   state_next = S_RD;
            OP_WRITE:  state_next = S_WR;
            OP_RECT:   state_next = S_RINIT;
            OP_CIRCLE: state_next = S_CINIT;
            OP_LINE:   state_next = S_LINIT;
            OP_CLEAR:  state_next = S_CLR;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = sts.pix_in ? S_RD2 : S_DONE;
      end
      S_RD2: begin
        cmd.rd_take = 1'b1;
        state_next  = S_DONE;
      end
      S_WR: begin
        cmd.put    = 1'b1;
        state_next = S_DONE;
      end
      S_RINIT: begin
        cmd.rect_init = 1'b1;
        state_next    = S_RECT;
      end
      S_RECT: begin
        if (sts.rect_empty) begin
          state_next = S_DONE;
        end else begin
          cmd.put = 1'b1;
          if (sts.rect_last) state_next = S_DONE;
          else cmd.rect_next = 1'b1;
        end
      end
      S_CINIT: begin
        if (sts.circ_none) begin
          state_next = S_DONE;
        end else begin
          cmd.circ_init = 1'b1;
          state_next    = S_CSQ;
        end
      end
      S_CSQ: begin
        cmd.circ_sq = 1'b1;
        state_next  = S_CSQRT0;
      end
      S_CSQRT0: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_CSQRT;
      end
      S_CSQRT: begin
        if (sts.sqrt_done) state_next = S_CSPAN;
      end
      S_CSPAN: begin
        cmd.circ_span = 1'b1;
        state_next    = S_CPIX;
      end
      S_CPIX: begin
        cmd.put = !sts.span_empty;
        if (sts.span_empty || sts.col_last) begin
          if (sts.row_last) begin
            state_next = S_DONE;
          end else begin
            cmd.row_next = 1'b1;
            state_next   = S_CSQ;
          end
        end else begin
          cmd.col_next = 1'b1;
        end
      end
      S_LINIT: begin
        cmd.line_init = 1'b1;
        state_next    = S_LCHK;
      end
      S_LCHK: begin
        if (sts.line_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.div_start_x = 1'b1;
          state_next      = S_LDX;
        end
      end
      S_LDX: begin
        if (sts.div_done) begin
          cmd.take_x      = 1'b1;
          cmd.div_start_y = 1'b1;
          state_next      = S_LDY;
        end
      end
      S_LDY: begin
        if (sts.div_done) begin
          cmd.take_y = 1'b1;
          state_next = S_LPOS;
        end
      end
      S_LPOS: begin
        cmd.line_pos = 1'b1;
        state_next   = S_LPUT;
      end
      S_LPUT: begin
        cmd.put    = 1'b1;
        state_next = sts.line_last ? S_DONE : S_LPOS;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.rsp_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.rsp_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  a_one_write_source: assert property (@(posedge clk) disable iff (rst)
    !(cmd.put && cmd.clr_step))
    else $error("pixel write and sweep write in the same cycle");

  a_rsp_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.rsp_load |-> (!rsp_valid || rsp_ready))
    else $error("result register overwritten while still held");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("accepted a second transaction before finishing the first");

endmodule

### sv/framebuffer_draw_engine.sv
// throughput: one transaction in flight; the next is taken once the result sits in
// the output register, pixel rate bounded by the single store write port
// reset: a clearing pass writes zero to all MAX_WIDTH*MAX_HEIGHT words, one per
// cycle, before the first transaction is accepted
module framebuffer_draw_engine #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [fde_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fde_pkg::CFG_DW-1:0]    cfg_data,
  // command transactions
  input  logic                          req_valid,
  output logic                          req_ready,
  input  fde_pkg::req_t                 req,
  // result transactions
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output fde_pkg::rsp_t                 rsp
);
  import fde_pkg::*;

  cmd_t cmd;   // controller strobes into the datapath
  sts_t sts;   // datapath conditions back to the controller

  // sequencing: one state per step of each drawing command
  fde_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_type  (req.req_type),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // pixel store, walkers, square root and divider units, result register
  fde_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

endmodule
